// File: rtl/core/igfa_pkg.sv
// ----------------------------------------------------------------------------
// igfa_pkg
// Shared types and constants of the idle-gap frame assembler.
// ----------------------------------------------------------------------------
package igfa_pkg;

	localparam int BUFFER_DEPTH = 64;
	localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
	localparam int BYTE_W       = 8;
	localparam int GAP_W        = 8;
	localparam int INDEX_W      = 6;
	localparam int LENGTH_W     = 7;

	localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(5);

	typedef enum logic [1:0] {
		OP_BYTE    = 2'd0,
		OP_TICK    = 2'd1,
		OP_READ    = 2'd2,
		OP_RELEASE = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [BYTE_W-1:0]   rx_byte;
		logic [INDEX_W-1:0]  read_index;
	} item_t;

	typedef struct packed {
		logic                frame_ready;
		logic [LENGTH_W-1:0] frame_length;
		logic [BYTE_W-1:0]   read_data;
		logic                overflow_discard;
		logic                byte_ignored;
	} result_t;

endpackage

// File: rtl/core/idle_gap_frame_assembler.sv
// ----------------------------------------------------------------------------
// idle_gap_frame_assembler
// Gathers received bytes into a frame buffer and closes the frame after an
// idle gap of timebase ticks.
// ----------------------------------------------------------------------------
// Takes one event per clock and returns one result beat per event, in the cycle
// after the event is taken; the delay is the registered read port of the
// frame buffer RAM, whose read data lands in the output register. A stalled
// result holds the input off only while that single output register is full
// and not being drained. The buffer needs no clearing after reset: reads at
// or beyond the current length return zero, so unwritten entries never show.
module idle_gap_frame_assembler (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  igfa_pkg::item_t           item,
	output logic                      result_valid,
	input  logic                      result_ready,
	output igfa_pkg::result_t         result,
	input  logic                      cfg_wr_en,
	input  logic [igfa_pkg::GAP_W-1:0] cfg_wr_data
);
	import igfa_pkg::*;

	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [GAP_W-1:0]  gap_q, gap_d, gap_inc;
	logic              rdy_q, rdy_d;
	logic [GAP_W-1:0]  gap_thr_q;

	logic              valid_s1;
	logic              rdy_s1;
	logic [CNT_W-1:0]  cnt_s1;
	logic              ovf_s1;
	logic              ign_s1;
	logic              hit_s1;

	logic              accept;
	logic              mem_we;
	logic              mem_re;
	logic              ovf, ign, hit;
	logic [BYTE_W-1:0] rd_data;

	assign item_ready = !valid_s1 || result_ready;
	assign accept     = item_valid && item_ready;

	// event decode
	always_comb begin
		cnt_d   = cnt_q;
		gap_d   = gap_q;
		rdy_d   = rdy_q;
		mem_we  = 1'b0;
		ovf     = 1'b0;
		ign     = 1'b0;
		hit     = 1'b0;
		gap_inc = (gap_q < gap_thr_q) ? gap_q + GAP_W'(1) : gap_q;
		case (item.opcode)
			OP_BYTE: begin
				if (rdy_q) begin
					ign = 1'b1;
				end else if (cnt_q < CNT_W'(BUFFER_DEPTH)) begin
					mem_we = 1'b1;
					gap_d  = '0;
					cnt_d  = cnt_q + CNT_W'(1);
				end else begin
					cnt_d = '0;
					gap_d = '0;
					rdy_d = 1'b0;
					ovf   = 1'b1;
				end
			end
			OP_TICK: begin
				if (!rdy_q) begin
					gap_d = gap_inc;
					if (gap_inc >= gap_thr_q && cnt_q != '0) begin
						rdy_d = 1'b1;
					end
				end
			end
			OP_READ: begin
				hit = (CNT_W + INDEX_W)'(item.read_index) < (CNT_W + INDEX_W)'(cnt_q);
			end
			OP_RELEASE: begin
				cnt_d = '0;
				gap_d = '0;
				rdy_d = 1'b0;
			end
			default: begin
				cnt_d = cnt_q;
			end
		endcase
	end

	assign mem_re = accept && (item.opcode == OP_READ);

	igfa_ram #(
		.DEPTH(BUFFER_DEPTH),
		.WIDTH(BYTE_W)
	) u_buf (
		.clk     (clk),
		.wr_en   (accept && mem_we),
		.wr_addr (cnt_q[ADDR_W-1:0]),
		.wr_data (item.rx_byte),
		.rd_en   (mem_re),
		.rd_addr (item.read_index[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			gap_q     <= '0;
			rdy_q     <= 1'b0;
			gap_thr_q <= GAP_RESET;
		end else begin
			if (cfg_wr_en) begin
				gap_thr_q <= cfg_wr_data;
			end
			if (accept) begin
				cnt_q <= cnt_d;
				gap_q <= gap_d;
				rdy_q <= rdy_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rdy_s1 <= rdy_d;
			cnt_s1 <= cnt_d;
			ovf_s1 <= ovf;
			ign_s1 <= ign;
			hit_s1 <= hit;
		end
	end

	assign result_valid            = valid_s1;
	assign result.frame_ready      = rdy_s1;
	assign result.frame_length     = LENGTH_W'(cnt_s1);
	assign result.read_data        = hit_s1 ? rd_data : '0;
	assign result.overflow_discard = ovf_s1;
	assign result.byte_ignored     = ign_s1;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(BUFFER_DEPTH))
		else $error("frame length beyond buffer depth");

	a_ready_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rdy_q |-> cnt_q != '0)
		else $error("frame ready with empty buffer");

	a_no_write_held: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mem_we) |-> !rdy_q)
		else $error("buffer written while frame held");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.opcode == OP_RELEASE) |=> (cnt_q == '0 && !rdy_q && gap_q == '0))
		else $error("release did not empty the frame");

endmodule

// File: rtl/core/igfa_ram.sv
// ----------------------------------------------------------------------------
// igfa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module igfa_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
